// ===== sv/cma_pkg.sv =====
// Package for the cascaded moving-average unit.
// Item structs, field widths, register indexes and fixed arithmetic constants.
// No dependencies.
`default_nettype none

package cma_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CHAN_BITS     = 2;
    localparam int WLEN_BITS     = 9;
    localparam int GAIN_BITS     = 17;
    localparam int COUNT_BITS    = 3;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_IDX_BITS  = 2;

    // running sum is four bits wider than a sample; a scaled value needs one guard bit
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int SCALED_BITS = SAMPLE_BITS + 1;
    localparam int FRAC_BITS   = 16;
    localparam int ROUND_HALF  = 32768;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_GAIN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_COUNT   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [CHAN_BITS-1:0]          channel_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CHAN_BITS-1:0]          channel_out;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/cascaded_moving_average_unit.sv =====
// Top level of the cascaded moving-average unit: sequencer, ring and sum memories,
// configuration registers and output register. Uses cma_pkg and cma_mac.
`default_nettype none

// Each item runs through its channel's cascade of boxcar stages one stage at a time on
// a single multiplier and ring/sum memories with one read and one write port each: the
// multiply state multiplies and reads the memories, the accumulate state after it
// accumulates, saturates and writes back. A filtered item passes through accept, a
// multiply/accumulate pair per stage and the output load; a bypassed item goes from
// accept straight to the output load, and no new item is accepted before then. The
// output register lets the next item in while a result waits. After reset, and after
// any write to window length, stage count or channel count, a clearing pass zeroes the
// ring and sum memories, during which no item is accepted.
module cascaded_moving_average_unit #(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_STAGES   = 4,
    parameter int MAX_WINDOW   = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire cma_pkg::in_item_t                  s_item,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output cma_pkg::out_item_t                      m_item,
    input  wire logic                               cfg_we,
    input  wire logic [cma_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [cma_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import cma_pkg::*;

    localparam int CH_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STG_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_DEPTH  = MAX_CHANNELS * MAX_STAGES;
    localparam int SUM_AW     = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int RING_DEPTH = SUM_DEPTH * MAX_WINDOW;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_DONE  = 5'b01000,
        ST_CLEAR = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [WLEN_BITS-1:0]  window_length_reg;
    logic [GAIN_BITS-1:0]  window_gain_reg;
    logic [COUNT_BITS-1:0] stage_count_reg;
    logic [COUNT_BITS-1:0] channel_count_reg;

    logic [POS_W-1:0] positions_reg [MAX_CHANNELS];

    logic signed [SCALED_BITS-1:0] ring_mem [RING_DEPTH];
    logic signed [SUM_BITS-1:0]    sum_mem [SUM_DEPTH];
    logic signed [SCALED_BITS-1:0] ring_rd_reg;
    logic signed [SUM_BITS-1:0]    sum_rd_reg;

    logic [RING_AW-1:0]            clr_reg, clr_next;
    logic [CHAN_BITS-1:0]          ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [STG_W-1:0]              stage_reg, stage_next;
    logic                          m_valid_reg, m_valid_next;
    out_item_t                     out_reg, out_next;

    logic                  accept;
    logic                  cfg_clear;
    logic                  bypass;
    logic [CH_IDX_W-1:0]   in_slot;
    logic [CH_IDX_W-1:0]   ch_slot;
    logic [LEN_W-1:0]      len_eff;
    logic [POS_W-1:0]      pos_cur;
    logic [LEN_W-1:0]      pos_inc;
    logic [POS_W-1:0]      pos_wrap;
    logic [COUNT_BITS:0]   stages_eff;
    logic [STG_W-1:0]      stage_last;
    logic [SUM_AW-1:0]     sum_addr;
    logic [RING_AW-1:0]    ring_addr;
    logic                  pos_we;
    logic                  mem_we;
    logic [SUM_AW-1:0]     sum_waddr;
    logic [RING_AW-1:0]    ring_waddr;
    logic signed [SUM_BITS-1:0]    sum_wdata;
    logic signed [SCALED_BITS-1:0] ring_wdata;
    logic                  sum_we;

    logic signed [SCALED_BITS-1:0] scaled;
    logic signed [SUM_BITS-1:0]    sum_new;
    logic signed [SAMPLE_BITS-1:0] x_sat;

    cma_mac u_mac (
        .aclk       (aclk),
        .mul_en     (state_reg == ST_MUL),
        .x_in       (x_reg),
        .gain       (window_gain_reg),
        .sum_in     (sum_rd_reg),
        .ring_in    (ring_rd_reg),
        .scaled_out (scaled),
        .sum_out    (sum_new),
        .sat_out    (x_sat)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign cfg_clear = cfg_we && (cfg_index == REG_WINDOW_LENGTH ||
                                  cfg_index == REG_STAGE_COUNT ||
                                  cfg_index == REG_CHANNEL_COUNT);

    assign in_slot = CH_IDX_W'(s_item.channel_in);
    assign ch_slot = CH_IDX_W'(ch_reg);

    assign bypass = (window_length_reg == '0) ||
                    ({1'b0, s_item.channel_in} >= channel_count_reg) ||
                    (32'(s_item.channel_in) >= MAX_CHANNELS);

    assign len_eff = (32'(window_length_reg) > MAX_WINDOW) ? LEN_W'(MAX_WINDOW)
                                                           : LEN_W'(window_length_reg);

    always_comb begin
        pos_cur = positions_reg[in_slot];
        if (LEN_W'(pos_cur) >= len_eff) begin
            pos_cur = '0;
        end
    end

    assign pos_inc  = LEN_W'(pos_reg) + LEN_W'(1);
    assign pos_wrap = (pos_inc >= len_eff) ? '0 : POS_W'(pos_inc);

    always_comb begin
        if (stage_count_reg == '0) begin
            stages_eff = (COUNT_BITS+1)'(1);
        end else if (32'(stage_count_reg) > MAX_STAGES) begin
            stages_eff = (COUNT_BITS+1)'(MAX_STAGES);
        end else begin
            stages_eff = {1'b0, stage_count_reg};
        end
    end
    assign stage_last = STG_W'(stages_eff - (COUNT_BITS+1)'(1));

    assign sum_addr  = SUM_AW'(32'(ch_slot) * MAX_STAGES + 32'(stage_reg));
    assign ring_addr = RING_AW'(32'(sum_addr) * MAX_WINDOW + 32'(pos_reg));

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        ch_next      = ch_reg;
        x_next       = x_reg;
        pos_next     = pos_reg;
        stage_next   = stage_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        pos_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_next    = s_item.channel_in;
                    x_next     = s_item.sample_in;
                    pos_next   = pos_cur;
                    stage_next = '0;
                    state_next = bypass ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                x_next = x_sat;
                if (stage_reg == stage_last) begin
                    pos_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    stage_next = stage_reg + STG_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.sample_out  = x_reg;
                    out_next.channel_out = ch_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                clr_next = clr_reg + RING_AW'(1);
                if (32'(clr_reg) == RING_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear) begin
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            m_valid_reg       <= 1'b0;
            window_length_reg <= '0;
            window_gain_reg   <= GAIN_BITS'(65536);
            stage_count_reg   <= COUNT_BITS'(1);
            channel_count_reg <= COUNT_BITS'(1);
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                positions_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_clear) begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    positions_reg[i] <= '0;
                end
            end else if (pos_we) begin
                positions_reg[ch_slot] <= pos_wrap;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[WLEN_BITS-1:0];
                    REG_WINDOW_GAIN:   window_gain_reg   <= cfg_wdata[GAIN_BITS-1:0];
                    REG_STAGE_COUNT:   stage_count_reg   <= cfg_wdata[COUNT_BITS-1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg    <= ch_next;
        x_reg     <= x_next;
        pos_reg   <= pos_next;
        stage_reg <= stage_next;
        out_reg   <= out_next;
    end

    // memory write port: zero sweep while clearing, write-back on accumulate
    always_comb begin
        mem_we     = 1'b0;
        sum_we     = 1'b0;
        ring_waddr = ring_addr;
        sum_waddr  = sum_addr;
        ring_wdata = scaled;
        sum_wdata  = sum_new;
        if (state_reg == ST_CLEAR) begin
            mem_we     = 1'b1;
            sum_we     = (32'(clr_reg) < SUM_DEPTH);
            ring_waddr = clr_reg;
            sum_waddr  = SUM_AW'(clr_reg);
            ring_wdata = '0;
            sum_wdata  = '0;
        end else if (state_reg == ST_ACC) begin
            mem_we = 1'b1;
            sum_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rd_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_addr];
    end

    a_acc_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) |-> $past(state_reg == ST_MUL))
        else $error("accumulate without preceding multiply");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_clear |=> (state_reg == ST_CLEAR) && (clr_reg == '0))
        else $error("reconfiguration did not start a clearing pass");

    a_stage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL || state_reg == ST_ACC) |-> (stage_reg <= stage_last))
        else $error("stage counter past configured cascade depth");

endmodule

`default_nettype wire

// ===== sv/cma_mac.sv =====
// Shared scale-and-accumulate unit: registered multiply with rounding, then
// running-sum update and Q1.15 saturation. Uses cma_pkg.
`default_nettype none

module cma_mac (
    input  wire logic                                  aclk,
    input  wire logic                                  mul_en,
    input  wire logic signed [cma_pkg::SAMPLE_BITS-1:0] x_in,
    input  wire logic [cma_pkg::GAIN_BITS-1:0]          gain,
    input  wire logic signed [cma_pkg::SUM_BITS-1:0]    sum_in,
    input  wire logic signed [cma_pkg::SCALED_BITS-1:0] ring_in,
    output logic signed [cma_pkg::SCALED_BITS-1:0]      scaled_out,
    output logic signed [cma_pkg::SUM_BITS-1:0]         sum_out,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0]      sat_out
);
    import cma_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(-(2 ** (SAMPLE_BITS - 1)));

    logic signed [PROD_BITS-1:0] x_ext;
    logic signed [PROD_BITS-1:0] gain_ext;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] prod_reg;

    assign x_ext     = PROD_BITS'(x_in);
    assign gain_ext  = PROD_BITS'($signed({1'b0, gain}));
    assign prod_next = x_ext * gain_ext + PROD_BITS'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // division by 2^16 is an arithmetic shift; with the added half it rounds to nearest, ties upward
    assign scaled_out = prod_reg[FRAC_BITS +: SCALED_BITS];
    assign sum_out    = sum_in + SUM_BITS'(scaled_out) - SUM_BITS'(ring_in);

    always_comb begin
        if (sum_out > SAT_HI) begin
            sat_out = SAT_HI[SAMPLE_BITS-1:0];
        end else if (sum_out < SAT_LO) begin
            sat_out = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_out = sum_out[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire
